// ===== src/chgw_pkg.sv =====
// Shared types and constants for the gift-wrapping convex hull block.
package chgw_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned TagW   = 16;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic        [TagW-1:0]   tag;
  } pt_t;

  typedef struct packed {
    logic neg;
    logic left;
  } cmp_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_LEFT,
    ST_HULL,
    ST_DRAIN
  } state_t;

endpackage

// ===== src/chgw_cell.sv =====
// One storage cell of the rotating point chain.
module chgw_cell (
  input  logic          clk,
  input  logic          ld,
  input  chgw_pkg::pt_t ld_pt,
  input  logic          sh,
  input  chgw_pkg::pt_t sh_pt,
  output chgw_pkg::pt_t q
);

  chgw_pkg::pt_t q_r;

  always_ff @(posedge clk) begin
    if (ld) begin
      q_r <= ld_pt;
    end else if (sh) begin
      q_r <= sh_pt;
    end
  end

  assign q = q_r;

endmodule

// ===== src/chgw_cmp.sv =====
// Orientation and leftmost comparison of a point against the current candidate.
module chgw_cmp (
  input  chgw_pkg::pt_t  piv,
  input  chgw_pkg::pt_t  pe,
  input  chgw_pkg::pt_t  pc,
  output chgw_pkg::cmp_t res
);

  logic signed [chgw_pkg::CoordW:0]     ax, ay, bx, by;
  logic signed [2*chgw_pkg::CoordW+1:0] pa, pb;
  logic signed [2*chgw_pkg::CoordW+2:0] cr;

  always_comb begin
    ax = $signed({pe.x[chgw_pkg::CoordW-1], pe.x}) - $signed({piv.x[chgw_pkg::CoordW-1], piv.x});
    ay = $signed({pe.y[chgw_pkg::CoordW-1], pe.y}) - $signed({piv.y[chgw_pkg::CoordW-1], piv.y});
    bx = $signed({pc.x[chgw_pkg::CoordW-1], pc.x}) - $signed({piv.x[chgw_pkg::CoordW-1], piv.x});
    by = $signed({pc.y[chgw_pkg::CoordW-1], pc.y}) - $signed({piv.y[chgw_pkg::CoordW-1], piv.y});
    pa = ax * by;
    pb = ay * bx;
    cr = $signed({pa[2*chgw_pkg::CoordW+1], pa}) - $signed({pb[2*chgw_pkg::CoordW+1], pb});
    res.neg  = cr[2*chgw_pkg::CoordW+2];
    res.left = (pe.x < pc.x) || ((pe.x == pc.x) && (pe.y < pc.y));
  end

endmodule

// ===== src/convex_hull_gift_wrapping.sv =====
// Convex hull of a streamed point set by gift wrapping over a rotating cell chain.
// Points load one per cycle into a chain of MAX_POINTS cells. The item with
// set_last starts the march: the n stored points rotate once through the chain
// head to find the leftmost start, then once more for each hull point, the
// orientation test working on one point per cycle at the head. Hull points
// collect in an output buffer and drain one per cycle while out_ready is high.
// No new item is taken until the hull of a set has drained.
module convex_hull_gift_wrapping #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [23:0]       in_pt_x,
  input  logic signed [23:0]       in_pt_y,
  input  logic        [15:0]       in_pt_tag,
  input  logic                     in_set_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic        [15:0]       out_hull_tag,
  output logic signed [23:0]       out_hull_x,
  output logic signed [23:0]       out_hull_y,
  output logic                     out_hull_end,
  output logic                     out_overflow
);

  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  chgw_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r, e_r, d_r, nm1;
  logic [IW-1:0] j_r, sw_r, bidx_r, bidx_fin;
  logic          drop_r, swv_r, cap_r, out_valid_r, out_end_r;
  chgw_pkg::pt_t p_r, old_r, best_r, start_r, best_fin, head, eff, in_pt, out_pt_r;
  chgw_pkg::cmp_t cmp;
  chgw_pkg::pt_t cell_q [MAX_POINTS];
  chgw_pkg::pt_t cell_d [MAX_POINTS];
  chgw_pkg::pt_t buf_mem [MAX_POINTS];

  logic acc, room, j_last, upd, hit, full_e, take, shift, wr_en;
  logic [IW-1:0] wr_addr;

  assign in_ready = (state_r == chgw_pkg::ST_LOAD);
  assign acc      = in_valid && in_ready;
  assign room     = cnt_r < CW'(MAX_POINTS);
  assign nm1      = cnt_r - 1'b1;
  assign j_last   = (CW'(j_r) == nm1);
  assign head     = cell_q[0];
  assign shift    = (state_r == chgw_pkg::ST_LEFT) || (state_r == chgw_pkg::ST_HULL);
  assign take     = !out_valid_r || out_ready;
  assign full_e   = e_r >= CW'(MAX_POINTS);

  always_comb begin
    in_pt.x   = in_pt_x;
    in_pt.y   = in_pt_y;
    in_pt.tag = in_pt_tag;
  end

  always_comb begin
    if (swv_r && (j_r == '0)) begin
      eff = p_r;
    end else if (swv_r && (sw_r != '0) && (j_r == sw_r)) begin
      eff = old_r;
    end else begin
      eff = head;
    end
  end

  chgw_cmp u_cmp (
    .piv (p_r),
    .pe  (eff),
    .pc  (best_r),
    .res (cmp)
  );

  genvar gi;
  generate
    for (gi = 0; gi < MAX_POINTS; gi++) begin : g_cell
      if (gi == MAX_POINTS - 1) begin : g_end
        assign cell_d[gi] = eff;
      end else begin : g_mid
        assign cell_d[gi] = (nm1 == CW'(gi)) ? eff : cell_q[gi+1];
      end
      chgw_cell u_cell (
        .clk   (clk),
        .ld    (acc && room && (cnt_r == CW'(gi))),
        .ld_pt (in_pt),
        .sh    (shift),
        .sh_pt (cell_d[gi]),
        .q     (cell_q[gi])
      );
    end
  endgenerate

  always_comb begin
    if (state_r == chgw_pkg::ST_LEFT) begin
      upd = (j_r == '0) || cmp.left;
    end else begin
      upd = (j_r == IW'(1)) || ((j_r > IW'(1)) && cmp.neg);
    end
    best_fin = upd ? eff : best_r;
    bidx_fin = upd ? j_r : bidx_r;
    hit      = (best_fin.x == start_r.x) && (best_fin.y == start_r.y);
    wr_en    = j_last && ((state_r == chgw_pkg::ST_LEFT) ||
               ((state_r == chgw_pkg::ST_HULL) && !hit && !full_e));
    wr_addr  = (state_r == chgw_pkg::ST_LEFT) ? '0 : e_r[IW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      chgw_pkg::ST_LOAD: begin
        if (acc && in_set_last) state_nxt = chgw_pkg::ST_LEFT;
      end
      chgw_pkg::ST_LEFT: begin
        if (j_last) state_nxt = (cnt_r == CW'(1)) ? chgw_pkg::ST_DRAIN : chgw_pkg::ST_HULL;
      end
      chgw_pkg::ST_HULL: begin
        if (j_last && (hit || full_e)) state_nxt = chgw_pkg::ST_DRAIN;
      end
      chgw_pkg::ST_DRAIN: begin
        if ((d_r == e_r) && take) state_nxt = chgw_pkg::ST_LOAD;
      end
      default: state_nxt = chgw_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chgw_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      j_r         <= '0;
      swv_r       <= 1'b0;
      sw_r        <= '0;
      e_r         <= '0;
      d_r         <= '0;
      cap_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r) inside
        chgw_pkg::ST_LOAD: begin
          if (acc) begin
            if (room) cnt_r <= cnt_r + 1'b1;
            else      drop_r <= 1'b1;
            if (in_set_last) begin
              j_r   <= '0;
              swv_r <= 1'b0;
            end
          end
        end
        chgw_pkg::ST_LEFT, chgw_pkg::ST_HULL: begin
          j_r <= j_last ? '0 : j_r + 1'b1;
          if (j_last) begin
            swv_r <= 1'b1;
            sw_r  <= bidx_fin;
            d_r   <= '0;
            if (state_r == chgw_pkg::ST_LEFT) begin
              e_r   <= CW'(1);
              cap_r <= 1'b0;
            end else if (!hit) begin
              if (full_e) cap_r <= 1'b1;
              else        e_r   <= e_r + 1'b1;
            end
          end
        end
        chgw_pkg::ST_DRAIN: begin
          if (take && (d_r != e_r)) d_r <= d_r + 1'b1;
          if (take && (d_r == e_r)) begin
            cnt_r  <= '0;
            drop_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
      if (take) out_valid_r <= (state_r == chgw_pkg::ST_DRAIN) && (d_r != e_r);
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      best_r <= best_fin;
      bidx_r <= bidx_fin;
      if (swv_r && (j_r == '0)) old_r <= head;
      if (j_last) begin
        p_r <= best_fin;
        if (state_r == chgw_pkg::ST_LEFT) start_r <= best_fin;
      end
    end
    if (wr_en) buf_mem[wr_addr] <= best_fin;
    if (take && (state_r == chgw_pkg::ST_DRAIN) && (d_r != e_r)) begin
      out_pt_r  <= buf_mem[d_r[IW-1:0]];
      out_end_r <= (d_r == e_r - 1'b1);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hull_tag = out_pt_r.tag;
  assign out_hull_x   = out_pt_r.x;
  assign out_hull_y   = out_pt_r.y;
  assign out_hull_end = out_end_r;
  assign out_overflow = drop_r || cap_r;

endmodule

// ===== test/tb_top.sv =====
// Testbench for the gift-wrapping convex hull block: directed and random sets checked against a predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned Slots = 64;

  typedef struct {
    logic [15:0]        tag;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic               last_pt;
    logic               ovf;
  } hull_pt_t;

  class hull_scoreboard;
    logic signed [23:0] px[Slots];
    logic signed [23:0] py[Slots];
    logic [15:0]        ptag[Slots];
    int unsigned        count;
    bit                 dropped;
    hull_pt_t           pending[$];
    int unsigned        errors;

    function new();
      count = 0;
      dropped = 0;
      errors = 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      logic signed [23:0] tx, ty;
      logic [15:0]        tt;
      tx = px[a]; ty = py[a]; tt = ptag[a];
      px[a] = px[b]; py[a] = py[b]; ptag[a] = ptag[b];
      px[b] = tx; py[b] = ty; ptag[b] = tt;
    endfunction

    function longint turn(int unsigned a, int unsigned b);
      longint ax, ay, bx, by;
      ax = longint'(px[a]) - longint'(px[0]);
      ay = longint'(py[a]) - longint'(py[0]);
      bx = longint'(px[b]) - longint'(px[0]);
      by = longint'(py[b]) - longint'(py[0]);
      return ax * by - ay * bx;
    endfunction

    function void wrap_hull();
      int unsigned        best, emitted;
      logic signed [23:0] sx, sy;
      bit                 cap;
      hull_pt_t           hp;
      hull_pt_t           found[$];
      best = 0;
      for (int unsigned i = 1; i < count; i++) begin
        if (px[i] < px[best] || (px[i] == px[best] && py[i] < py[best])) best = i;
      end
      swap_slots(0, best);
      sx = px[0];
      sy = py[0];
      emitted = 0;
      cap = 0;
      forever begin
        hp.tag = ptag[0]; hp.x = px[0]; hp.y = py[0]; hp.last_pt = 0; hp.ovf = 0;
        found = {found, hp};
        emitted++;
        if (count < 2) break;
        best = 1;
        for (int unsigned i = 2; i < count; i++) begin
          if (turn(i, best) < 0) best = i;
        end
        swap_slots(0, best);
        if (px[0] == sx && py[0] == sy) break;
        if (emitted >= Slots) begin
          cap = 1;
          break;
        end
      end
      found[found.size()-1].last_pt = 1;
      foreach (found[i]) begin
        found[i].ovf = dropped || cap;
        pending = {pending, found[i]};
      end
      count = 0;
      dropped = 0;
    endfunction

    function void note_point(logic signed [23:0] x, logic signed [23:0] y,
                             logic [15:0] tag, logic last);
      if (count < Slots) begin
        px[count] = x; py[count] = y; ptag[count] = tag;
        count++;
      end else begin
        dropped = 1;
      end
      if (last && count > 0) wrap_hull();
    endfunction

    function void check_result(hull_pt_t got);
      hull_pt_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected hull point tag %h x %h y %h", $time, got.tag, got.x, got.y);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.tag !== want.tag) begin
        $display("%0t: hull_tag expected %h actual %h", $time, want.tag, got.tag);
        errors++;
      end
      if (got.x !== want.x) begin
        $display("%0t: hull_x expected %h actual %h", $time, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: hull_y expected %h actual %h", $time, want.y, got.y);
        errors++;
      end
      if (got.last_pt !== want.last_pt) begin
        $display("%0t: hull_end expected %b actual %b", $time, want.last_pt, got.last_pt);
        errors++;
      end
      if (got.ovf !== want.ovf) begin
        $display("%0t: overflow expected %b actual %b", $time, want.ovf, got.ovf);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic signed [23:0] in_pt_x = 0;
  logic signed [23:0] in_pt_y = 0;
  logic [15:0]        in_pt_tag = 0;
  logic               in_set_last = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [15:0]        out_hull_tag;
  logic signed [23:0] out_hull_x;
  logic signed [23:0] out_hull_y;
  logic               out_hull_end;
  logic               out_overflow;

  hull_scoreboard sb = new();
  bit             quiet = 0;
  int unsigned    out_hold = 0;

  convex_hull_gift_wrapping i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_pt_x     (in_pt_x),
    .in_pt_y     (in_pt_y),
    .in_pt_tag   (in_pt_tag),
    .in_set_last (in_set_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_hull_tag(out_hull_tag),
    .out_hull_x  (out_hull_x),
    .out_hull_y  (out_hull_y),
    .out_hull_end(out_hull_end),
    .out_overflow(out_overflow)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    hull_pt_t got;
    if (rst_n && out_valid && out_ready) begin
      got.tag = out_hull_tag; got.x = out_hull_x; got.y = out_hull_y;
      got.last_pt = out_hull_end; got.ovf = out_overflow;
      sb.check_result(got);
    end
    if (!rst_n || quiet) begin
      out_ready <= rst_n;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_ready <= 0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_hold <= $urandom_range(1, 18) - 1;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  task automatic send_point(logic signed [23:0] x, logic signed [23:0] y,
                            logic [15:0] tag, logic last);
    int unsigned gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_pt_x <= x;
    in_pt_y <= y;
    in_pt_tag <= tag;
    in_set_last <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_point(x, y, tag, last);
  endtask

  function automatic logic signed [23:0] rand_coord(int unsigned mode);
    case (mode)
      0: return 24'($signed($urandom_range(0, 8)) - 4);
      1: return 24'($signed($urandom_range(0, 40)) - 20) <<< 12;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_set(int unsigned size, int unsigned mode);
    for (int unsigned i = 0; i < size; i++) begin
      send_point(rand_coord(mode), rand_coord(mode), 16'($urandom), i == size - 1);
    end
  endtask

  initial begin
    int unsigned sent, size, set_no;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // single point at the extremes
    send_point(24'sh7FFFFF, -24'sh800000, 16'hFFFF, 1);
    send_point(-24'sh800000, 24'sh7FFFFF, 16'h0000, 1);
    // square of corners with an interior point
    send_point(24'sh7FFFFF, 24'sh7FFFFF, 16'h0001, 0);
    send_point(-24'sh800000, 24'sh7FFFFF, 16'h0002, 0);
    send_point(0, 0, 16'h0003, 0);
    send_point(-24'sh800000, -24'sh800000, 16'h0004, 0);
    send_point(24'sh7FFFFF, -24'sh800000, 16'h0005, 1);
    // duplicates, with a tie on the leftmost point
    send_point(5, 5, 16'h0010, 0);
    send_point(5, 5, 16'h0011, 0);
    send_point(-3, 2, 16'h0012, 0);
    send_point(-3, 2, 16'h0013, 1);
    // collinear run
    for (int i = 0; i < 5; i++) send_point(24'(i * 7), 24'(i * 3), 16'(16'h20 + i), i == 4);
    // lone point marked last in a full store is covered by the overflow set below

    sent = 16;
    set_no = 0;
    while (sent < 470) begin
      if (set_no == 3) size = 66;
      else if ($urandom_range(0, 39) == 0) size = $urandom_range(60, 70);
      else size = $urandom_range(1, 12);
      if (sent > 390) quiet = 1;
      send_set(size, $urandom_range(0, 2));
      sent += size;
      set_no++;
    end
    in_valid <= 0;
    wait (sb.pending.size() == 0);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
